// File: design/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg: shared constants, types and tables for the seconds-to-calendar block
// Holds the reciprocal constants for the constant divisions, the day-split
// record that passes between the front and back parts, and the month table.
// ----------------------------------------------------------------------------
`default_nettype none

package esc_pkg;

    // 24856 * 86400: a whole number of days at least 2^31, so that adding it
    // makes every count non-negative without moving the time of day.
    localparam logic [32:0] DAY_OFFSET = 33'd2147558400;

    // 86400 = 128 * 675; floor(2^36 / 675).
    localparam int unsigned RECIP_675_SHIFT = 36;
    localparam logic [26:0] RECIP_675       = 27'd101806632;
    localparam logic [9:0]  DIV_675         = 10'd675;

    // Days from 1901-01-01 to the offset epoch day zero (25202 - 24856).
    localparam logic [15:0] DAY_BIAS        = 16'd346;
    localparam logic [15:0] DAY_BIAS_PLUS1  = 16'd347;

    // Four-year cycle: 1461 days; floor(2^26 / 1461).
    localparam logic [15:0] RECIP_1461      = 16'd45933;
    localparam logic [10:0] CYCLE_DAYS      = 11'd1461;

    // Division by 60: floor(2^22 / 60) for seconds, floor(2^16 / 60) for minutes.
    localparam logic [16:0] RECIP_60_SEC    = 17'd69905;
    localparam logic [10:0] RECIP_60_MIN    = 11'd1092;
    localparam logic [5:0]  DIV_60          = 6'd60;

    localparam logic [10:0] BASE_YEAR       = 11'd1901;
    localparam logic [10:0] YEAR_DAYS_1     = 11'd365;
    localparam logic [10:0] YEAR_DAYS_2     = 11'd730;
    localparam logic [10:0] YEAR_DAYS_3     = 11'd1095;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_AW    = 1;

    // Whole days since 1901-01-01 and the second of that day.
    typedef struct packed {
        logic [15:0] days;
        logic [16:0] rem;
    } t_day_split;

    // Days before the start of month idx (0 = January) in a normal or leap year.
    function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
        logic [8:0] base;
        case (idx)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd365;
        endcase
        if (leap && (idx >= 4'd2)) begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

`default_nettype wire

// File: design/esc_fifo.sv
// ----------------------------------------------------------------------------
// esc_fifo: short queue between the front and back parts
// Register-based FIFO of day-split records; push and pop may share a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_fifo
    import esc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire t_day_split i_data,
    output logic            o_full,
    input  wire logic       i_pop,
    output t_day_split      o_data,
    output logic            o_empty
);

    t_day_split              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]     r_wp, n_wp;
    logic [QUEUE_AW-1:0]     r_rp, n_rp;
    logic [QUEUE_AW:0]       r_cnt, n_cnt;
    logic                    w_push, w_pop;

    assign o_full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wp = (r_wp == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (w_pop) begin
            n_rp = (r_rp == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: design/esc_front.sv
// ----------------------------------------------------------------------------
// esc_front: split a signed second count into days and second of day
// Four stages: offset, reciprocal multiply, back-multiply, correct.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_front
    import esc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire logic [31:0] i_epoch_seconds,
    output logic             o_full,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_day_split       o_split
);

    logic        w_en;
    logic        r_v1, r_v2, r_v3, r_v4;
    logic [32:0] r_u;
    logic [52:0] r_prod;
    logic [25:0] r2_v;
    logic [6:0]  r2_lo;
    logic [16:0] r_qest;
    logic [25:0] r_qm;
    logic [25:0] r3_v;
    logic [6:0]  r3_lo;
    t_day_split  r_split;

    logic [25:0] w_diff;
    logic [10:0] w_r11;
    logic        w_corr;
    logic [10:0] w_rfix;
    logic [26:0] w_qm_full;

    // Advance the whole pipe unless the last stage holds a record the queue refuses.
    assign w_en    = !r_v4 || i_ready;
    assign o_full  = !w_en;
    assign o_valid = r_v4;
    assign o_split = r_split;

    assign w_qm_full = 27'(r_prod[52:RECIP_675_SHIFT]) * 27'(DIV_675);
    assign w_diff    = r3_v - r_qm;
    assign w_r11     = w_diff[10:0];
    assign w_corr    = (w_r11 >= 11'(DIV_675));
    assign w_rfix    = w_corr ? (w_r11 - 11'(DIV_675)) : w_r11;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_push;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_u           <= {i_epoch_seconds[31], i_epoch_seconds} + DAY_OFFSET;
            r_prod        <= 53'(r_u[32:7]) * 53'(RECIP_675);
            r2_v          <= r_u[32:7];
            r2_lo         <= r_u[6:0];
            r_qest        <= r_prod[52:RECIP_675_SHIFT];
            r_qm          <= w_qm_full[25:0];
            r3_v          <= r2_v;
            r3_lo         <= r2_lo;
            r_split.days  <= r_qest[15:0] + (w_corr ? DAY_BIAS_PLUS1 : DAY_BIAS);
            r_split.rem   <= {w_rfix[9:0], r3_lo};
        end
    end

endmodule

`default_nettype wire

// File: design/esc_back.sv
// ----------------------------------------------------------------------------
// esc_back: turn days and second of day into date and time of day
// Six stages; the last one is the output register that pop takes results from.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_back
    import esc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire t_day_split  i_split,
    output logic             o_take,
    input  wire logic        i_pop,
    output logic             o_empty,
    output logic [10:0]      o_year,
    output logic [3:0]       o_month,
    output logic [4:0]       o_day,
    output logic [4:0]       o_hour,
    output logic [5:0]       o_minute,
    output logic [5:0]       o_second
);

    logic w_en;
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;

    // stage 1
    logic [15:0] r1_d;
    logic [16:0] r1_rem;
    logic [31:0] r1_pd;
    logic [33:0] r1_pr;
    // stage 2
    logic [15:0] r2_d;
    logic [16:0] r2_rem;
    logic [5:0]  r2_c;
    logic [16:0] r2_t1;
    logic [10:0] r2_mm;
    logic [16:0] r2_t2;
    // stage 3
    logic [5:0]  r3_c;
    logic [10:0] r3_e;
    logic [10:0] r3_mm;
    logic [5:0]  r3_sec;
    // stage 4
    logic [8:0]  r4_doy;
    logic        r4_leap;
    logic [10:0] r4_year;
    logic [21:0] r4_pm;
    logic [10:0] r4_mm;
    logic [5:0]  r4_sec;
    // stage 5
    logic [3:0]  r5_month;
    logic [4:0]  r5_day;
    logic [10:0] r5_year;
    logic [4:0]  r5_hr;
    logic [10:0] r5_h60;
    logic [10:0] r5_mm;
    logic [5:0]  r5_sec;
    // stage 6
    logic [10:0] r6_year;
    logic [3:0]  r6_month;
    logic [4:0]  r6_day;
    logic [4:0]  r6_hour;
    logic [5:0]  r6_minute;
    logic [5:0]  r6_second;

    logic [15:0] w_ediff;
    logic [11:0] w_e12;
    logic        w_ecorr;
    logic [16:0] w_sdiff;
    logic [6:0]  w_s7;
    logic        w_scorr;
    logic [1:0]  w_yi;
    logic [10:0] w_ybase;
    logic [3:0]  w_midx;
    logic [8:0]  w_mstart;
    logic [8:0]  w_dom;
    logic [4:0]  w_hest;
    logic [10:0] w_mdiff;
    logic [6:0]  w_m7;
    logic        w_mcorr;

    // Hold everything while the output register holds an untaken result.
    assign w_en    = !r_v6 || i_pop;
    assign o_take  = w_en && i_valid;
    assign o_empty = !r_v6;

    assign o_year   = r6_year;
    assign o_month  = r6_month;
    assign o_day    = r6_day;
    assign o_hour   = r6_hour;
    assign o_minute = r6_minute;
    assign o_second = r6_second;

    // Stage 3: correct cycle and minute estimates by at most one.
    assign w_ediff = r2_d - r2_t1[15:0];
    assign w_e12   = w_ediff[11:0];
    assign w_ecorr = (w_e12 >= 12'(CYCLE_DAYS));
    assign w_sdiff = r2_rem - r2_t2;
    assign w_s7    = w_sdiff[6:0];
    assign w_scorr = (w_s7 >= 7'(DIV_60));

    // Stage 4: year inside the four-year cycle, the leap year last.
    always_comb begin
        if (r3_e < YEAR_DAYS_1) begin
            w_yi    = 2'd0;
            w_ybase = '0;
        end else if (r3_e < YEAR_DAYS_2) begin
            w_yi    = 2'd1;
            w_ybase = YEAR_DAYS_1;
        end else if (r3_e < YEAR_DAYS_3) begin
            w_yi    = 2'd2;
            w_ybase = YEAR_DAYS_2;
        end else begin
            w_yi    = 2'd3;
            w_ybase = YEAR_DAYS_3;
        end
    end

    // Stage 5: month index is the count of February to December starts at or below the day.
    always_comb begin
        w_midx = '0;
        for (int k = 1; k < 12; k++) begin
            if (r4_doy >= month_start(r4_leap, 4'(k))) begin
                w_midx = w_midx + 4'd1;
            end
        end
    end
    assign w_mstart = month_start(r4_leap, w_midx);
    assign w_dom    = r4_doy - w_mstart + 9'd1;
    assign w_hest   = r4_pm[20:16];

    // Stage 6: correct the hour estimate and form the minute.
    assign w_mdiff = r5_mm - r5_h60;
    assign w_m7    = w_mdiff[6:0];
    assign w_mcorr = (w_m7 >= 7'(DIV_60));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_d      <= i_split.days;
            r1_rem    <= i_split.rem;
            r1_pd     <= 32'(i_split.days) * 32'(RECIP_1461);
            r1_pr     <= 34'(i_split.rem) * 34'(RECIP_60_SEC);

            r2_d      <= r1_d;
            r2_rem    <= r1_rem;
            r2_c      <= r1_pd[31:26];
            r2_t1     <= 17'(r1_pd[31:26]) * 17'(CYCLE_DAYS);
            r2_mm     <= r1_pr[32:22];
            r2_t2     <= 17'(r1_pr[32:22]) * 17'(DIV_60);

            r3_c      <= w_ecorr ? (r2_c + 6'd1) : r2_c;
            r3_e      <= w_ecorr ? 11'(w_e12 - 12'(CYCLE_DAYS)) : w_e12[10:0];
            r3_mm     <= w_scorr ? (r2_mm + 11'd1) : r2_mm;
            r3_sec    <= w_scorr ? 6'(w_s7 - 7'(DIV_60)) : w_s7[5:0];

            r4_doy    <= 9'(r3_e - w_ybase);
            r4_leap   <= (w_yi == 2'd3);
            r4_year   <= BASE_YEAR + {3'd0, r3_c, 2'b00} + 11'(w_yi);
            r4_pm     <= 22'(r3_mm) * 22'(RECIP_60_MIN);
            r4_mm     <= r3_mm;
            r4_sec    <= r3_sec;

            r5_month  <= w_midx + 4'd1;
            r5_day    <= w_dom[4:0];
            r5_year   <= r4_year;
            r5_hr     <= w_hest;
            r5_h60    <= 11'(w_hest) * 11'(DIV_60);
            r5_mm     <= r4_mm;
            r5_sec    <= r4_sec;

            r6_year   <= r5_year;
            r6_month  <= r5_month;
            r6_day    <= r5_day;
            r6_hour   <= w_mcorr ? (r5_hr + 5'd1) : r5_hr;
            r6_minute <= w_mcorr ? 6'(w_m7 - 7'(DIV_60)) : w_m7[5:0];
            r6_second <= r5_sec;
        end
    end

endmodule

`default_nettype wire

// File: design/epoch_seconds_to_calendar.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar: signed epoch seconds to Gregorian date and time
// Input channel: drive i_epoch_seconds and raise push; a transfer happens on
// a rising edge with push high and full low. Output channel: while empty
// is low the oldest result sits on o_year..o_second; raise pop to take it.
// Structure: a four-stage front splits the count into days and second of day
// by reciprocal multiplication, a two-entry queue decouples it from a six-stage
// back that derives year (four-year cycles), month, day, hour, minute, second.
// Path: an input passes the four front stages, a queue entry and the six back
// stages. Throughput: one item per cycle unless pop stalls, set by the
// one-stage-per-step pipelines; each multiplier is used once per item.
// Stall: when pop stays low the back pipe holds its output register and
// freezes, the queue fills, then the front freezes and raises full; no
// result is dropped or repeated, and the pipes resume where they stopped.
// Reset: i_rst_n low at a clock edge empties both pipes and the queue; only
// valid data moves on, so the first result after reset depends only on input.
// ----------------------------------------------------------------------------
`default_nettype none

module epoch_seconds_to_calendar
    import esc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [31:0] i_epoch_seconds,
    output logic             empty,
    input  wire logic        pop,
    output logic [10:0]      o_year,
    output logic [3:0]       o_month,
    output logic [4:0]       o_day,
    output logic [4:0]       o_hour,
    output logic [5:0]       o_minute,
    output logic [5:0]       o_second
);

    // Front to queue.
    logic       w_front_valid;
    t_day_split w_front_split;
    logic       w_q_full;

    // Queue to back.
    t_day_split w_q_data;
    logic       w_q_empty;
    logic       w_back_take;

    // Classify: offset the count and split off whole days.
    esc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_epoch_seconds (i_epoch_seconds),
        .o_full          (full),
        .o_valid         (w_front_valid),
        .i_ready         (!w_q_full),
        .o_split         (w_front_split)
    );

    // Buffer split records so each side can stall on its own.
    esc_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_valid),
        .i_data  (w_front_split),
        .o_full  (w_q_full),
        .i_pop   (w_back_take),
        .o_data  (w_q_data),
        .o_empty (w_q_empty)
    );

    // Carry out: calendar and clock fields, held in the output register.
    esc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (!w_q_empty),
        .i_split  (w_q_data),
        .o_take   (w_back_take),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_year   (o_year),
        .o_month  (o_month),
        .o_day    (o_day),
        .o_hour   (o_hour),
        .o_minute (o_minute),
        .o_second (o_second)
    );

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the epoch seconds to calendar converter
// Drives signed 32-bit second counts through the push/full side and checks
// every popped date and time against typed-in dates or an in-bench calendar
// predictor. A short directed table covers the range ends, midnight, leap days
// and the sign change; random counts near day, year and range boundaries follow.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  HALF_PERIOD     = 4;
    localparam int  RESET_CYCLES    = 3;
    localparam int  RANDOM_ITEMS    = 800;
    localparam int  IDLE_PERCENT    = 36;
    localparam int  CALM_FIRST      = 300;    // no idling on either side
    localparam int  CALM_LAST       = 420;    //   for this stretch of items
    localparam int  PAUSE_AT        = 600;    // sender waits for a full drain here
    localparam int  DRAIN_CYCLES    = 24;     // margin after the last expected result
    localparam int  STALL_LIMIT     = 2000;   // cycles without any transfer
    localparam int  MAX_REPORTS     = 10;

    localparam longint MINUTE_SECONDS  = 60;
    localparam longint HOUR_SECONDS    = 3600;
    localparam longint DAY_SECONDS     = 86400;
    localparam longint EPOCH_YEAR      = 1970;
    localparam longint NORMAL_DAYS     = 365;
    localparam longint LEAP_DAYS       = 366;
    localparam int     FEB_29_OFFSET   = 59;

    // Days before each month in a normal year; leap years add one from March on.
    localparam int MONTH_OFFSET [0:11] =
        '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    typedef struct packed {
        logic [10:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_calendar;

    // One directed row: the count, and a typed-in date where it is obvious.
    typedef struct packed {
        logic [31:0] secs;
        logic        pinned;
        t_calendar   want;
    } t_dir_row;

    localparam int NUM_DIRECTED = 22;
    localparam t_dir_row DIRECTED_ROWS [NUM_DIRECTED] = '{
        // epoch itself
        '{32'h0000_0000, 1'b1, '{11'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0}},
        // one second before the epoch: floored remainder
        '{32'hFFFF_FFFF, 1'b1, '{11'd1969, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59}},
        // largest positive count
        '{32'h7FFF_FFFF, 1'b1, '{11'd2038, 4'd1, 5'd19, 5'd3, 6'd14, 6'd7}},
        // most negative count
        '{32'h8000_0000, 1'b1, '{11'd1901, 4'd12, 5'd13, 5'd20, 6'd45, 6'd52}},
        // start of the second day
        '{32'd86400,     1'b1, '{11'd1970, 4'd1, 5'd2, 5'd0, 6'd0, 6'd0}},
        // century leap day
        '{32'd951782400, 1'b1, '{11'd2000, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0}},
        // last second of the century
        '{32'd946684799, 1'b1, '{11'd1999, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59}},
        '{32'd946684800, 1'b0, '0},
        '{32'd1,         1'b0, '0},
        '{32'd59,        1'b0, '0},
        '{32'd3600,      1'b0, '0},
        '{32'd86399,     1'b0, '0},
        '{32'hFFFE_AE80, 1'b0, '0},   // minus one day
        '{32'hFFFE_AE7F, 1'b0, '0},   // minus one day and a second
        '{32'hFE1E_CC80, 1'b0, '0},   // 1969-01-01
        '{32'd31535999,  1'b0, '0},
        '{32'd31536000,  1'b0, '0},
        '{32'd68169600,  1'b0, '0},
        '{32'd1709164800, 1'b0, '0},
        '{32'h5555_5555, 1'b0, '0},
        '{32'hAAAA_AAAA, 1'b0, '0},
        '{32'hB669_FD2E, 1'b0, '0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic [31:0] i_epoch_seconds = '0;
    logic        pop = 1'b0;
    logic        full;
    logic        empty;
    logic [10:0] o_year;
    logic [3:0]  o_month;
    logic [4:0]  o_day;
    logic [4:0]  o_hour;
    logic [5:0]  o_minute;
    logic [5:0]  o_second;

    t_calendar   pending_dates [$];   // dates owed by the block, oldest first
    int          mismatches = 0;
    int          quiet_cycles = 0;
    bit          calm = 1'b0;         // both sides run without idling

    always #(HALF_PERIOD) i_clk = ~i_clk;

    epoch_seconds_to_calendar u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_epoch_seconds (i_epoch_seconds),
        .empty           (empty),
        .pop             (pop),
        .o_year          (o_year),
        .o_month         (o_month),
        .o_day           (o_day),
        .o_hour          (o_hour),
        .o_minute        (o_minute),
        .o_second        (o_second)
    );

    // ------------------------------------------------------------------------
    // Calendar predictor
    // ------------------------------------------------------------------------
    function automatic bit is_leap_year(input longint yr);
        return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    endfunction

    function automatic longint year_length(input longint yr);
        return is_leap_year(yr) ? LEAP_DAYS : NORMAL_DAYS;
    endfunction

    // Day number (from the epoch) of January 1 of a year.
    function automatic longint year_start_day(input longint yr);
        longint d;
        longint y;
        d = 0;
        for (y = EPOCH_YEAR; y < yr; y++) d += year_length(y);
        for (y = yr; y < EPOCH_YEAR; y++) d -= year_length(y);
        return d;
    endfunction

    function automatic t_calendar to_calendar(input logic [31:0] raw);
        longint    secs;
        longint    days;
        longint    rem;
        longint    yr;
        longint    first;
        int        mon;
        bit        leap;
        t_calendar c;
        secs = longint'($signed(raw));
        // Floor split so the time of day is never negative.
        days = secs / DAY_SECONDS;
        rem  = secs % DAY_SECONDS;
        if (rem < 0) begin
            rem  += DAY_SECONDS;
            days -= 1;
        end
        // Walk years outward from the epoch until the day falls inside one.
        yr = EPOCH_YEAR;
        while (days < 0) begin
            yr   -= 1;
            days += year_length(yr);
        end
        while (days >= year_length(yr)) begin
            days -= year_length(yr);
            yr   += 1;
        end
        leap = is_leap_year(yr);
        mon  = 11;
        first = MONTH_OFFSET[mon] + ((leap && mon >= 2) ? 1 : 0);
        while (mon > 0 && days < first) begin
            mon -= 1;
            first = MONTH_OFFSET[mon] + ((leap && mon >= 2) ? 1 : 0);
        end
        c.year   = 11'(yr);
        c.month  = 4'(mon + 1);
        c.day    = 5'(days - first + 1);
        c.hour   = 5'(rem / HOUR_SECONDS);
        c.minute = 6'((rem % HOUR_SECONDS) / MINUTE_SECONDS);
        c.second = 6'(rem % MINUTE_SECONDS);
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Random counts: mostly near day, year, leap-day and range boundaries, some uniform
    // ------------------------------------------------------------------------
    function automatic logic [31:0] pick_seconds();
        longint base;
        longint wiggle;
        longint yr;
        wiggle = longint'($urandom_range(8)) - 4;
        case ($urandom_range(5))
            0, 1: return $urandom();
            2: begin
                // near a midnight somewhere in range
                base = (longint'($urandom_range(49710)) - 24855) * DAY_SECONDS;
                return 32'(base + wiggle);
            end
            3: begin
                // near New Year
                yr = longint'($urandom_range(2037, 1902));
                return 32'(year_start_day(yr) * DAY_SECONDS + wiggle);
            end
            4: begin
                // around Feb 28/29 and Mar 1 of a leap year
                yr = 4 * longint'($urandom_range(509, 476));
                base = (year_start_day(yr) + FEB_29_OFFSET) * DAY_SECONDS;
                return 32'(base + longint'($urandom_range(2)) * DAY_SECONDS
                           - DAY_SECONDS + wiggle);
            end
            default: begin
                // hug the two ends of the 32-bit range
                if ($urandom_range(1) == 0) begin
                    return 32'h7FFF_FFFF - 32'($urandom_range(200000));
                end else begin
                    return 32'h8000_0000 + 32'($urandom_range(200000));
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Input side: one transfer per call, random idle cycles in front of it.
    // push is driven once per edge; it only drops when a gap is taken or the sender pauses or ends.
    // ------------------------------------------------------------------------
    task automatic send_seconds(input logic [31:0] secs, input t_calendar want);
        int gap;
        gap = 0;
        if (!calm) begin
            while ($urandom_range(99) < IDLE_PERCENT) gap++;
        end
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push            <= 1'b1;
        i_epoch_seconds <= secs;
        // Hold until the edge that sees push high with room in the block.
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        pending_dates.push_back(want);
    endtask

    // ------------------------------------------------------------------------
    // Output side: pop with random stalls, compare each transfer field by field
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        pop <= calm || ($urandom_range(99) >= IDLE_PERCENT);
    end

    always @(posedge i_clk) begin
        t_calendar got;
        t_calendar want;
        got = '{o_year, o_month, o_day, o_hour, o_minute, o_second};
        if (i_rst_n && pop && !empty) begin
            if (pending_dates.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("[%0t] unexpected result %0d-%0d-%0d %0d:%0d:%0d", $realtime,
                             got.year, got.month, got.day, got.hour, got.minute, got.second);
                end
            end else begin
                want = pending_dates.pop_front();
                if (got.year !== want.year || got.month !== want.month ||
                    got.day !== want.day || got.hour !== want.hour ||
                    got.minute !== want.minute || got.second !== want.second) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("[%0t] mismatch: expected %0d-%0d-%0d %0d:%0d:%0d",
                                 $realtime,
                                 want.year, want.month, want.day,
                                 want.hour, want.minute, want.second);
                        $display("                    got %0d-%0d-%0d %0d:%0d:%0d",
                                 got.year, got.month, got.day,
                                 got.hour, got.minute, got.second);
                    end
                end
            end
        end
    end

    // Watchdog: any transfer on either side clears it.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("Test completed with failures");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [31:0] secs;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: typed-in dates where pinned, predictor otherwise.
        for (int r = 0; r < NUM_DIRECTED; r++) begin
            send_seconds(DIRECTED_ROWS[r].secs,
                         DIRECTED_ROWS[r].pinned ? DIRECTED_ROWS[r].want
                                                 : to_calendar(DIRECTED_ROWS[r].secs));
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= CALM_FIRST) && (n < CALM_LAST);
            if (n == PAUSE_AT) begin
                // Drop push and wait for the block to drain completely.
                push <= 1'b0;
                while (pending_dates.size() != 0) @(posedge i_clk);
            end
            secs = pick_seconds();
            send_seconds(secs, to_calendar(secs));
        end
        calm = 1'b0;
        push <= 1'b0;

        while (pending_dates.size() != 0) @(posedge i_clk);
        // Anything arriving now is unexpected and gets flagged by the checker.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending_dates.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
